@@ src/pppahdlc_pkg.sv @@
// Shared types, constants and the FCS-16 byte update for the PPP async HDLC deframer.
package pppahdlc_pkg;

   // Field widths
   localparam int ACTION_W   = 2;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 11;
   localparam int COUNT_W    = 12;
   localparam int FCS_W      = 16;
   localparam int KIND_W     = 3;

   // Frame size limit defaults
   localparam int MAX_FRAME_BYTES_DEFAULT = 2048;
   localparam logic [COUNT_W-1:0] MAX_FRAME_RESET = 12'd2048;

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;

   // CSR port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_KEEP = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_MAX  = 3'd4;

   // Special characters
   localparam logic [BYTE_W-1:0] CHAR_FLAG   = 8'h7e;
   localparam logic [BYTE_W-1:0] CHAR_ESC    = 8'h7d;
   localparam logic [BYTE_W-1:0] CHAR_XOR    = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ADDR   = 8'hff;
   localparam logic [BYTE_W-1:0] CHAR_CTRL   = 8'h03;
   localparam logic [FCS_W-1:0]  FCS_INIT    = 16'hffff;
   localparam logic [FCS_W-1:0]  FCS_GOOD    = 16'hf0b8;
   localparam logic [COUNT_W-1:0] HDR_TRAILER_BYTES = 12'd4;
   localparam logic [COUNT_W-1:0] SHORT_FRAME_BYTES = 12'd3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BYTE     = 2'd0,
      ACT_ARM      = 2'd1,
      ACT_AUTOSYNC = 2'd2,
      ACT_DISABLE  = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      EV_NONE     = 3'd0,
      EV_STORED   = 3'd1,
      EV_GOOD     = 3'd2,
      EV_CRC_ERR  = 3'd3,
      EV_OVERFLOW = 3'd4
   } event_type;

   // Classified transaction held in the queue
   typedef struct packed {
      action_type        action;
      logic [BYTE_W-1:0] rx_byte;
      logic              is_flag;
      logic              is_esc;
      logic              is_drop;
   } entry_type;

   // One CRC-16/PPP (reflected 0x1021) byte step
   function automatic logic [FCS_W-1:0] fcs_byte(input logic [FCS_W-1:0] fcs,
                                                 input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] b;
      logic [FCS_W-1:0]  t;
      b = fcs[7:0] ^ c;
      b = b ^ {b[3:0], 4'b0000};
      t = {b, 8'h00} ^ {5'b00000, b, 3'b000} ^ {12'h000, b[7:4]};
      return {8'h00, fcs[15:8]} ^ t;
   endfunction

endpackage

@@ src/pppahdlc_front.sv @@
// Front end: classifies incoming transactions and queues them for the back end.
module pppahdlc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              keep_control_chars,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pppahdlc_pkg::ACTION_W-1:0] req_action,
   input  logic [pppahdlc_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                              head_valid,
   output pppahdlc_pkg::entry_type           head_entry,
   input  logic                              head_pop
);

   localparam int PTR_W = $clog2(pppahdlc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pppahdlc_pkg::QUEUE_DEPTH + 1);

   pppahdlc_pkg::entry_type queue_ff [pppahdlc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   pppahdlc_pkg::entry_type new_entry;
   logic push;
   logic pop;

   // classification
   always_comb begin
      new_entry.action  = pppahdlc_pkg::action_type'(req_action);
      new_entry.rx_byte = req_rx_byte;
      new_entry.is_flag = (req_rx_byte == pppahdlc_pkg::CHAR_FLAG);
      new_entry.is_esc  = (req_rx_byte == pppahdlc_pkg::CHAR_ESC);
      new_entry.is_drop = (req_rx_byte < pppahdlc_pkg::CHAR_XOR) && !keep_control_chars;
   end

   assign req_stall  = (count_ff == CNT_W'(pppahdlc_pkg::QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_entry = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

@@ src/pppahdlc_back.sv @@
// Back end: receiver state, unescaping, FCS check and the registered result stage.
module pppahdlc_back #(
   parameter int MAX_FRAME_BYTES = pppahdlc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pppahdlc_pkg::COUNT_W-1:0]   max_frame_bytes,
   input  logic                               head_valid,
   input  pppahdlc_pkg::entry_type            head_entry,
   output logic                               head_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_accepted,
   output logic                               rsp_rx_ready,
   output logic [pppahdlc_pkg::KIND_W-1:0]    rsp_event_kind,
   output logic [pppahdlc_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [pppahdlc_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic [pppahdlc_pkg::COUNT_W-1:0]   rsp_payload_length,
   output logic [pppahdlc_pkg::FCS_W-1:0]     rsp_protocol_id
);

   localparam int COUNT_MAX = (1 << pppahdlc_pkg::COUNT_W) - 1;
   localparam logic [pppahdlc_pkg::COUNT_W-1:0] LIMIT_CAP =
      pppahdlc_pkg::COUNT_W'((MAX_FRAME_BYTES > COUNT_MAX) ? COUNT_MAX : MAX_FRAME_BYTES);

   logic armed_ff, armed_in;
   logic autosync_ff, autosync_in;
   logic escape_ff, escape_in;
   logic skip_ff, skip_in;
   logic [pppahdlc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [pppahdlc_pkg::FCS_W-1:0]   fcs_ff, fcs_in;
   logic [pppahdlc_pkg::FCS_W-1:0]   proto_ff, proto_in;

   logic                               out_valid_ff, out_valid_in;
   logic                               out_acc_ff, out_acc_in;
   logic                               out_ready_ff;
   pppahdlc_pkg::event_type            out_kind_ff, out_kind_in;
   logic [pppahdlc_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic [pppahdlc_pkg::INDEX_W-1:0]   out_idx_ff, out_idx_in;
   logic [pppahdlc_pkg::COUNT_W-1:0]   out_len_ff, out_len_in;
   logic [pppahdlc_pkg::FCS_W-1:0]     out_proto_ff, out_proto_in;

   logic [pppahdlc_pkg::COUNT_W-1:0] limit;
   logic [pppahdlc_pkg::BYTE_W-1:0]  c_val;
   logic                             store;
   logic                             pop;

   assign limit    = (max_frame_bytes > LIMIT_CAP) ? LIMIT_CAP : max_frame_bytes;
   assign pop      = head_valid && (!out_valid_ff || !rsp_stall);
   assign head_pop = pop;

   always_comb begin
      armed_in     = armed_ff;
      autosync_in  = autosync_ff;
      escape_in    = escape_ff;
      skip_in      = skip_ff;
      count_in     = count_ff;
      fcs_in       = fcs_ff;
      proto_in     = proto_ff;
      out_acc_in   = 1'b1;
      out_kind_in  = pppahdlc_pkg::EV_NONE;
      out_byte_in  = '0;
      out_idx_in   = '0;
      out_len_in   = '0;
      out_proto_in = '0;
      c_val        = head_entry.rx_byte;
      store        = 1'b0;

      case (head_entry.action)
         pppahdlc_pkg::ACT_ARM: begin
            count_in = '0;
            fcs_in   = pppahdlc_pkg::FCS_INIT;
            proto_in = '0;
            armed_in = 1'b1;
         end
         pppahdlc_pkg::ACT_AUTOSYNC: begin
            autosync_in = 1'b1;
            armed_in    = 1'b0;
         end
         pppahdlc_pkg::ACT_DISABLE: begin
            armed_in = 1'b0;
         end
         default: begin
            // autosync: flag or escape wakes an idle receiver
            if (!armed_ff && autosync_ff && (head_entry.is_flag || head_entry.is_esc)) begin
               count_in = '0;
               fcs_in   = pppahdlc_pkg::FCS_INIT;
               proto_in = '0;
               armed_in = 1'b1;
            end
            if (!armed_in) begin
               out_acc_in = 1'b0;
            end else if (skip_ff) begin
               if (head_entry.is_flag) begin
                  skip_in  = 1'b0;
                  count_in = '0;
                  fcs_in   = pppahdlc_pkg::FCS_INIT;
                  proto_in = '0;
               end
            end else if (head_entry.is_drop) begin
               // control char discarded
            end else if (escape_ff) begin
               escape_in = 1'b0;
               if (head_entry.is_flag) begin
                  // abort sequence
                  count_in = '0;
                  fcs_in   = pppahdlc_pkg::FCS_INIT;
                  proto_in = '0;
               end else begin
                  c_val = head_entry.rx_byte ^ pppahdlc_pkg::CHAR_XOR;
                  store = 1'b1;
               end
            end else if (head_entry.is_flag) begin
               if (fcs_in == pppahdlc_pkg::FCS_GOOD) begin
                  out_kind_in  = pppahdlc_pkg::EV_GOOD;
                  out_len_in   = (count_in >= pppahdlc_pkg::HDR_TRAILER_BYTES) ?
                                 count_in - pppahdlc_pkg::HDR_TRAILER_BYTES : '0;
                  out_proto_in = proto_in;
               end else if (count_in > pppahdlc_pkg::SHORT_FRAME_BYTES) begin
                  out_kind_in = pppahdlc_pkg::EV_CRC_ERR;
               end
               count_in = '0;
               fcs_in   = pppahdlc_pkg::FCS_INIT;
               proto_in = '0;
            end else if (head_entry.is_esc) begin
               escape_in = 1'b1;
            end else begin
               store = 1'b1;
            end

            if (store) begin
               if (count_in >= limit) begin
                  skip_in     = 1'b1;
                  count_in    = '0;
                  fcs_in      = pppahdlc_pkg::FCS_INIT;
                  proto_in    = '0;
                  out_kind_in = pppahdlc_pkg::EV_OVERFLOW;
               end else begin
                  fcs_in = pppahdlc_pkg::fcs_byte(fcs_in, c_val);
                  // leading address/control octets are checked but not stored
                  if (!(count_in == '0 && (c_val == pppahdlc_pkg::CHAR_ADDR ||
                                           c_val == pppahdlc_pkg::CHAR_CTRL))) begin
                     if (count_in == '0) begin
                        proto_in = {c_val, 8'h00};
                     end else if (count_in == pppahdlc_pkg::COUNT_W'(1)) begin
                        proto_in = {proto_in[15:8], c_val};
                     end
                     out_kind_in = pppahdlc_pkg::EV_STORED;
                     out_byte_in = c_val;
                     out_idx_in  = count_in[pppahdlc_pkg::INDEX_W-1:0];
                     count_in    = pppahdlc_pkg::COUNT_W'(count_in + 1'b1);
                  end
               end
            end
         end
      endcase

      out_valid_in = pop || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         autosync_ff  <= 1'b0;
         escape_ff    <= 1'b0;
         skip_ff      <= 1'b0;
         count_ff     <= '0;
         fcs_ff       <= pppahdlc_pkg::FCS_INIT;
         proto_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            armed_ff    <= armed_in;
            autosync_ff <= autosync_in;
            escape_ff   <= escape_in;
            skip_ff     <= skip_in;
            count_ff    <= count_in;
            fcs_ff      <= fcs_in;
            proto_ff    <= proto_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_acc_ff   <= out_acc_in;
         out_ready_ff <= armed_in;
         out_kind_ff  <= out_kind_in;
         out_byte_ff  <= out_byte_in;
         out_idx_ff   <= out_idx_in;
         out_len_ff   <= out_len_in;
         out_proto_ff <= out_proto_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_accepted       = out_acc_ff;
   assign rsp_rx_ready       = out_ready_ff;
   assign rsp_event_kind     = out_kind_ff;
   assign rsp_data_byte      = out_byte_ff;
   assign rsp_byte_index     = out_idx_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_protocol_id    = out_proto_ff;

endmodule

@@ src/ppp_async_hdlc_deframer.sv @@
// Top level of the PPP async HDLC receive deframer: CSRs, front end, queue and back end.
//
// Usage:
//  - req_ channel: one transaction per accepted cycle (req_valid high, req_stall low).
//    req_action 0 carries a received line byte in req_rx_byte; 1 arms the receiver,
//    2 starts autosync (wake on a flag or escape), 3 disables it.
//  - rsp_ channel: exactly one result per request, in order. rsp_event_kind tells
//    whether a byte was stored (with its index), a frame ended good (protocol and
//    payload length), with a CRC error, or overflowed the frame limit.
//  - APB port: offset 0x0 keep_control_chars, offset 0x4 max_frame_bytes (12 bits).
//    Write registers only while the block is idle.
// Timing:
//  - Throughput is one transaction per cycle while rsp_stall is low; the back end state
//    update (unescape, FCS byte step, count compare) is combinational logic.
//  - An accepted transaction is written into the 4-entry queue between the two ends
//    and from there into the result register.
//  - When rsp_stall holds the output register, the queue absorbs up to 4 more
//    transactions, after which req_stall rises.
//  - Reset (synchronous) empties the queue, disarms the receiver, clears autosync
//    and restores the CSR defaults.
module ppp_async_hdlc_deframer #(
   parameter int MAX_FRAME_BYTES = pppahdlc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pppahdlc_pkg::ACTION_W-1:0]     req_action,
   input  logic [pppahdlc_pkg::BYTE_W-1:0]       req_rx_byte,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_accepted,
   output logic                                  rsp_rx_ready,
   output logic [pppahdlc_pkg::KIND_W-1:0]       rsp_event_kind,
   output logic [pppahdlc_pkg::BYTE_W-1:0]       rsp_data_byte,
   output logic [pppahdlc_pkg::INDEX_W-1:0]      rsp_byte_index,
   output logic [pppahdlc_pkg::COUNT_W-1:0]      rsp_payload_length,
   output logic [pppahdlc_pkg::FCS_W-1:0]        rsp_protocol_id,
   // APB configuration
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pppahdlc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pppahdlc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pppahdlc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   logic                                 keep_ff;
   logic [pppahdlc_pkg::COUNT_W-1:0]     max_ff;
   logic                                 csr_wr;

   logic                                 head_valid;
   pppahdlc_pkg::entry_type              head_entry;
   logic                                 head_pop;

   // zero wait-state APB
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b0;
         max_ff  <= pppahdlc_pkg::MAX_FRAME_RESET;
      end else if (csr_wr) begin
         if (paddr == pppahdlc_pkg::CSR_ADDR_KEEP) begin
            keep_ff <= pwdata[0];
         end else if (paddr == pppahdlc_pkg::CSR_ADDR_MAX) begin
            max_ff <= pwdata[pppahdlc_pkg::COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == pppahdlc_pkg::CSR_ADDR_KEEP) begin
         prdata = {{(pppahdlc_pkg::CSR_DATA_W-1){1'b0}}, keep_ff};
      end else if (paddr == pppahdlc_pkg::CSR_ADDR_MAX) begin
         prdata = {{(pppahdlc_pkg::CSR_DATA_W-pppahdlc_pkg::COUNT_W){1'b0}}, max_ff};
      end
   end

   // front end: classify and queue
   pppahdlc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .keep_control_chars (keep_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_rx_byte        (req_rx_byte),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .head_pop           (head_pop)
   );

   // back end: receiver state and result register
   pppahdlc_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .max_frame_bytes    (max_ff),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .head_pop           (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_rx_ready       (rsp_rx_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_length (rsp_payload_length),
      .rsp_protocol_id    (rsp_protocol_id)
   );

endmodule
